@@ src/rlsh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row legalizer package
// Sizes, field widths, state encoding and status codes shared by the design.
// ----------------------------------------------------------------------------
package rlsh_pkg;

  localparam int MAX_CELLS  = 64;
  localparam int HEAP_DEPTH = 128;
  localparam int POS_BITS   = 24;

  localparam int WIDTH_W    = 16;
  localparam int CMD_W      = 2;
  localparam int COST_W     = 48;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = $clog2(MAX_CELLS);
  localparam int CNT_W      = $clog2(MAX_CELLS + 1);
  localparam int CW_AW      = $clog2(MAX_CELLS + 1);
  localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
  localparam int HCNT_W     = $clog2(HEAP_DEPTH + 1);

  // Sum of all cell widths.
  localparam int CW_W       = WIDTH_W + IDX_W + 1;
  // Breakpoint positions reach below row_begin by up to the used width.
  localparam int HPOS_W     = POS_BITS + 2;
  localparam int HWT_W      = CW_W + 3;
  localparam int HEAP_W     = HPOS_W + HWT_W;
  // Working width of positions and slopes.
  localparam int CALC_W     = 34;
  localparam int ACC_W      = 2 * CALC_W;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [1:0] {
    CMD_QUERY   = 2'd0,
    CMD_PUSH    = 2'd1,
    CMD_READOUT = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_NOFIT = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_ROW_BEGIN = 1'b0,
    REG_ROW_END   = 1'b1
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_USED,
    ST_HEAP,
    ST_HMUL,
    ST_HACC,
    ST_FIN,
    ST_FMUL,
    ST_FACC,
    ST_FMUL2,
    ST_FACC2,
    ST_INS_RD,
    ST_INS_CK,
    ST_INS_NEXT,
    ST_RB_RD,
    ST_RB_CK,
    ST_RF_RD,
    ST_RF_EMIT,
    ST_EMIT
  } state_t;

endpackage

@@ src/rlsh_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rlsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/row_legalizer_slope_heap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row legalizer with minimum weighted displacement
// Appends cells into one row and reports displacement cost and final positions.
// ----------------------------------------------------------------------------
// Cells arrive left to right on the input stream and are placed between
// row_begin and row_end so that the width-weighted displacement is minimal.
// in_tuser carries the command: a query returns the cost of appending a cell
// without changing anything, a push appends it and returns the same cost, a
// readout streams every cell's legal position in index order with tlast on
// the final one, and a clear empties the row. A cell that does not fit, or a
// full table, comes back with status 1 and leaves the row untouched; a readout
// of an empty row returns status 2. The block works on one transaction at a
// time. A query or push steps one at a time through every breakpoint it
// retires and, for a push, every breakpoint the new entries move past, since
// the sorted breakpoint list lives in a RAM with a single read and a single
// write port. A readout of N cells runs a backward pass that folds the suffix
// minimum into the constraint RAM and a forward pass that emits the positions
// one at a time and holds while the output is stalled. There is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module row_legalizer_slope_heap (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cell_width[15:0], target_pos[39:16]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // cost[47:0], cell_index[53:48], position[77:54]
  output logic        out_tlast,
  output logic [1:0]  out_tuser,  // status[1:0]
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PB = rlsh_pkg::POS_BITS;
  localparam int CW = rlsh_pkg::CALC_W;

  // Registers.
  logic signed [PB-1:0] row_begin_r, row_end_r;

  // Control state.
  rlsh_pkg::state_t state_r, state_nxt;
  logic [rlsh_pkg::CNT_W-1:0]  cell_cnt_r, cell_cnt_nxt;
  logic [rlsh_pkg::HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [rlsh_pkg::HCNT_W-1:0] k_r, k_nxt;
  logic [rlsh_pkg::IDX_W-1:0]  i_r, i_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Working registers.
  logic [1:0]                        cmd_r, cmd_nxt;
  logic [rlsh_pkg::WIDTH_W-1:0]      w_r, w_nxt;
  logic signed [PB-1:0]              tgt_r, tgt_nxt;
  logic [rlsh_pkg::CW_W-1:0]         used_r, used_nxt;
  logic signed [CW-1:0]              tabs_r, tabs_nxt;
  logic signed [CW-1:0]              limit_r, limit_nxt;
  logic signed [CW-1:0]              cur_r, cur_nxt;
  logic signed [CW-1:0]              slope_r, slope_nxt;
  logic signed [CW-1:0]              fin_r, fin_nxt;
  logic signed [rlsh_pkg::ACC_W-1:0] cost_r, cost_nxt;
  logic signed [CW-1:0]              mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic signed [rlsh_pkg::ACC_W-1:0] prod_r;
  logic [rlsh_pkg::STATUS_W-1:0]     stat_r, stat_nxt;
  logic signed [CW-1:0]              ins_pos_r, ins_pos_nxt, ins_wt_r, ins_wt_nxt;
  logic signed [CW-1:0]              ins2_pos_r, ins2_pos_nxt, ins2_wt_r, ins2_wt_nxt;
  logic                              ins2_r, ins2_nxt;
  logic signed [PB-1:0]              run_r, run_nxt;

  // Output registers.
  logic [rlsh_pkg::COST_W-1:0]   o_cost_r, o_cost_nxt;
  logic [rlsh_pkg::IDX_W-1:0]    o_idx_r, o_idx_nxt;
  logic [PB-1:0]                 o_pos_r, o_pos_nxt;
  logic                          o_last_r, o_last_nxt;
  logic [rlsh_pkg::STATUS_W-1:0] o_stat_r, o_stat_nxt;

  // Memory ports.
  logic                           heap_we;
  logic [rlsh_pkg::HEAP_AW-1:0]   heap_waddr, heap_raddr;
  logic [rlsh_pkg::HEAP_W-1:0]    heap_wdata, heap_rdata;
  logic                           cw_we;
  logic [rlsh_pkg::CW_AW-1:0]     cw_waddr, cw_raddr;
  logic [rlsh_pkg::CW_W-1:0]      cw_wdata, cw_rdata;
  logic                           cp_we;
  logic [rlsh_pkg::IDX_W-1:0]     cp_waddr;
  logic [PB-1:0]                  cp_wdata, cp_rdata;

  // Shared decode.
  logic                 accept, ofree;
  logic signed [CW-1:0] rb, re, wid, tgt;
  logic signed [CW-1:0] hp, hw, used_c, tabs_c, limit_c;
  logic                 take, fail_limit, fail_cur, fail_full;
  logic signed [CW-1:0] lo_c, lo2_c, fin_c, dist_c;
  logic [1:0]           extra;
  logic signed [PB-1:0] cp_val, run_c;
  logic                 rb_last, rf_last;
  logic [rlsh_pkg::CW_W-1:0] cw_fwd;

  assign accept = in_tvalid && in_tready;
  assign ofree  = !out_valid_r || out_tready;

  assign rb  = CW'(row_begin_r);
  assign re  = CW'(row_end_r);
  assign wid = CW'({1'b0, w_r});
  assign tgt = CW'(tgt_r);

  assign hp = CW'($signed(heap_rdata[rlsh_pkg::HPOS_W-1:0]));
  assign hw = CW'($signed(heap_rdata[rlsh_pkg::HEAP_W-1:rlsh_pkg::HPOS_W]));

  // Width already used by the row; entry zero of the cumulative table is zero.
  assign used_c  = (cell_cnt_r == '0) ? '0 : CW'({1'b0, cw_rdata});
  assign tabs_c  = tgt - used_c;
  assign limit_c = re - used_c - wid;
  assign fail_limit = limit_c < rb;

  // A breakpoint is retired while it lies right of the target on a falling
  // slope or beyond the last position that still leaves room for the cell.
  assign take = ((slope_r < 0) && (hp > tabs_r)) || (hp > limit_r);

  assign fail_cur = cur_r < rb;
  assign lo_c     = (slope_r >= 0) ? cur_r : tabs_r;
  assign lo2_c    = (lo_c < rb) ? rb : lo_c;
  assign fin_c    = (lo2_c < limit_r) ? lo2_c : limit_r;
  assign dist_c   = (fin_r >= tabs_r) ? (fin_r - tabs_r) : (tabs_r - fin_r);

  assign extra     = {1'b0, slope_r > 0} + {1'b0, tabs_r > rb};
  assign fail_full = ({1'b0, k_r} + (rlsh_pkg::HCNT_W + 1)'(extra))
                     > (rlsh_pkg::HCNT_W + 1)'(rlsh_pkg::HEAP_DEPTH);

  // Readout passes.
  assign cp_val  = $signed(cp_rdata);
  assign rb_last = ({1'b0, i_r} == cell_cnt_r - 1'b1);
  assign run_c   = (rb_last || (cp_val < run_r)) ? cp_val : run_r;
  assign rf_last = rb_last;
  assign cw_fwd  = (i_r == '0) ? '0 : cw_rdata;

  // Read addresses follow the working indexes so that data holds while stalled.
  assign heap_raddr = rlsh_pkg::HEAP_AW'(k_r - 1'b1);
  assign cw_raddr   = (state_r == rlsh_pkg::ST_RF_RD || state_r == rlsh_pkg::ST_RF_EMIT)
                      ? rlsh_pkg::CW_AW'(i_r) : rlsh_pkg::CW_AW'(cell_cnt_r);

  // --------------------------------------------------------------------------
  // Next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rlsh_pkg::ST_IDLE: begin
        if (accept) begin
          case (rlsh_pkg::cmd_t'(in_tuser))
            rlsh_pkg::CMD_CLEAR: state_nxt = rlsh_pkg::ST_EMIT;
            rlsh_pkg::CMD_READOUT: begin
              state_nxt = (cell_cnt_r == '0) ? rlsh_pkg::ST_EMIT : rlsh_pkg::ST_RB_RD;
            end
            default: begin
              state_nxt = (cell_cnt_r >= rlsh_pkg::CNT_W'(rlsh_pkg::MAX_CELLS))
                          ? rlsh_pkg::ST_EMIT : rlsh_pkg::ST_USED;
            end
          endcase
        end
      end
      rlsh_pkg::ST_USED: begin
        if (fail_limit) begin
          state_nxt = rlsh_pkg::ST_EMIT;
        end else begin
          state_nxt = (k_r != '0) ? rlsh_pkg::ST_HEAP : rlsh_pkg::ST_FIN;
        end
      end
      rlsh_pkg::ST_HEAP: state_nxt = take ? rlsh_pkg::ST_HMUL : rlsh_pkg::ST_FIN;
      rlsh_pkg::ST_HMUL: state_nxt = rlsh_pkg::ST_HACC;
      rlsh_pkg::ST_HACC: state_nxt = (k_r != '0) ? rlsh_pkg::ST_HEAP : rlsh_pkg::ST_FIN;
      rlsh_pkg::ST_FIN:  state_nxt = fail_cur ? rlsh_pkg::ST_EMIT : rlsh_pkg::ST_FMUL;
      rlsh_pkg::ST_FMUL: state_nxt = rlsh_pkg::ST_FACC;
      rlsh_pkg::ST_FACC: state_nxt = rlsh_pkg::ST_FMUL2;
      rlsh_pkg::ST_FMUL2: state_nxt = rlsh_pkg::ST_FACC2;
      rlsh_pkg::ST_FACC2: begin
        if (fail_full || cmd_r != rlsh_pkg::CMD_PUSH) begin
          state_nxt = rlsh_pkg::ST_EMIT;
        end else if (slope_r > 0) begin
          state_nxt = rlsh_pkg::ST_INS_RD;
        end else if (tabs_r > rb) begin
          state_nxt = rlsh_pkg::ST_INS_NEXT;
        end else begin
          state_nxt = rlsh_pkg::ST_EMIT;
        end
      end
      rlsh_pkg::ST_INS_RD: begin
        if (k_r == '0) begin
          state_nxt = ins2_r ? rlsh_pkg::ST_INS_NEXT : rlsh_pkg::ST_EMIT;
        end else begin
          state_nxt = rlsh_pkg::ST_INS_CK;
        end
      end
      rlsh_pkg::ST_INS_CK: begin
        if (hp > ins_pos_r) begin
          state_nxt = rlsh_pkg::ST_INS_RD;
        end else begin
          state_nxt = ins2_r ? rlsh_pkg::ST_INS_NEXT : rlsh_pkg::ST_EMIT;
        end
      end
      rlsh_pkg::ST_INS_NEXT: state_nxt = rlsh_pkg::ST_INS_RD;
      rlsh_pkg::ST_RB_RD:    state_nxt = rlsh_pkg::ST_RB_CK;
      rlsh_pkg::ST_RB_CK: begin
        state_nxt = (i_r == '0) ? rlsh_pkg::ST_RF_RD : rlsh_pkg::ST_RB_RD;
      end
      rlsh_pkg::ST_RF_RD: state_nxt = rlsh_pkg::ST_RF_EMIT;
      rlsh_pkg::ST_RF_EMIT: begin
        if (ofree) begin
          state_nxt = rf_last ? rlsh_pkg::ST_IDLE : rlsh_pkg::ST_RF_RD;
        end
      end
      rlsh_pkg::ST_EMIT: begin
        if (ofree) begin
          state_nxt = rlsh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rlsh_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs.
  // --------------------------------------------------------------------------
  always_comb begin
    cell_cnt_nxt  = cell_cnt_r;
    hcnt_nxt      = hcnt_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    w_nxt         = w_r;
    tgt_nxt       = tgt_r;
    used_nxt      = used_r;
    tabs_nxt      = tabs_r;
    limit_nxt     = limit_r;
    cur_nxt       = cur_r;
    slope_nxt     = slope_r;
    fin_nxt       = fin_r;
    cost_nxt      = cost_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    stat_nxt      = stat_r;
    ins_pos_nxt   = ins_pos_r;
    ins_wt_nxt    = ins_wt_r;
    ins2_pos_nxt  = ins2_pos_r;
    ins2_wt_nxt   = ins2_wt_r;
    ins2_nxt      = ins2_r;
    run_nxt       = run_r;
    o_cost_nxt    = o_cost_r;
    o_idx_nxt     = o_idx_r;
    o_pos_nxt     = o_pos_r;
    o_last_nxt    = o_last_r;
    o_stat_nxt    = o_stat_r;
    heap_we       = 1'b0;
    heap_waddr    = rlsh_pkg::HEAP_AW'(k_r);
    heap_wdata    = {rlsh_pkg::HWT_W'(ins_wt_r), rlsh_pkg::HPOS_W'(ins_pos_r)};
    cw_we         = 1'b0;
    cw_waddr      = rlsh_pkg::CW_AW'(cell_cnt_r + 1'b1);
    cw_wdata      = rlsh_pkg::CW_W'(used_r + rlsh_pkg::CW_W'(w_r));
    cp_we         = 1'b0;
    cp_waddr      = i_r;
    cp_wdata      = PB'(fin_r);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rlsh_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_tuser;
          w_nxt     = in_tdata[15:0];
          tgt_nxt   = $signed(in_tdata[39:16]);
          k_nxt     = hcnt_r;
          cost_nxt  = '0;
          slope_nxt = -CW'({1'b0, in_tdata[15:0]});
          cur_nxt   = re;
          stat_nxt  = rlsh_pkg::STS_OK;
          i_nxt     = rlsh_pkg::IDX_W'(cell_cnt_r - 1'b1);
          case (rlsh_pkg::cmd_t'(in_tuser))
            rlsh_pkg::CMD_CLEAR: begin
              cell_cnt_nxt = '0;
              hcnt_nxt     = '0;
            end
            rlsh_pkg::CMD_READOUT: begin
              if (cell_cnt_r == '0) begin
                stat_nxt = rlsh_pkg::STS_EMPTY;
              end
            end
            default: begin
              if (cell_cnt_r >= rlsh_pkg::CNT_W'(rlsh_pkg::MAX_CELLS)) begin
                stat_nxt = rlsh_pkg::STS_NOFIT;
              end
            end
          endcase
        end
      end
      rlsh_pkg::ST_USED: begin
        used_nxt  = rlsh_pkg::CW_W'(used_c);
        tabs_nxt  = tabs_c;
        limit_nxt = limit_c;
        if (fail_limit) begin
          stat_nxt = rlsh_pkg::STS_NOFIT;
        end
      end
      rlsh_pkg::ST_HEAP: begin
        if (take) begin
          mul_a_nxt = cur_r - hp;
          mul_b_nxt = slope_r + wid;
          cur_nxt   = hp;
          slope_nxt = slope_r + hw;
          k_nxt     = k_r - 1'b1;
        end
      end
      rlsh_pkg::ST_HACC: cost_nxt = cost_r + prod_r;
      rlsh_pkg::ST_FIN: begin
        if (fail_cur) begin
          stat_nxt = rlsh_pkg::STS_NOFIT;
          cost_nxt = '0;
        end
        fin_nxt   = fin_c;
        mul_a_nxt = cur_r - fin_c;
        mul_b_nxt = slope_r + wid;
      end
      rlsh_pkg::ST_FACC: begin
        cost_nxt  = cost_r + prod_r;
        mul_a_nxt = wid;
        mul_b_nxt = dist_c;
      end
      rlsh_pkg::ST_FACC2: begin
        cost_nxt = cost_r + prod_r;
        if (fail_full) begin
          stat_nxt = rlsh_pkg::STS_NOFIT;
          cost_nxt = '0;
        end else if (cmd_r == rlsh_pkg::CMD_PUSH) begin
          // Commit the cell and drop the retired breakpoints.
          cw_we        = 1'b1;
          cp_we        = 1'b1;
          cp_waddr     = rlsh_pkg::IDX_W'(cell_cnt_r);
          cell_cnt_nxt = cell_cnt_r + 1'b1;
          hcnt_nxt     = k_r;
          ins_pos_nxt  = cur_r;
          ins_wt_nxt   = slope_r;
          ins2_nxt     = tabs_r > rb;
          ins2_pos_nxt = (tabs_r < fin_r) ? tabs_r : fin_r;
          ins2_wt_nxt  = (wid <<< 1) + ((slope_r < 0) ? slope_r : '0);
        end
      end
      rlsh_pkg::ST_INS_RD: begin
        if (k_r == '0) begin
          heap_we  = 1'b1;
          hcnt_nxt = hcnt_r + 1'b1;
        end
      end
      rlsh_pkg::ST_INS_CK: begin
        heap_we = 1'b1;
        if (hp > ins_pos_r) begin
          // Shift the larger entry up one place.
          heap_wdata = heap_rdata;
          k_nxt      = k_r - 1'b1;
        end else begin
          hcnt_nxt = hcnt_r + 1'b1;
        end
      end
      rlsh_pkg::ST_INS_NEXT: begin
        ins_pos_nxt = ins2_pos_r;
        ins_wt_nxt  = ins2_wt_r;
        ins2_nxt    = 1'b0;
        k_nxt       = hcnt_r;
      end
      rlsh_pkg::ST_RB_CK: begin
        // The suffix minimum replaces the constraint in place; a second
        // readout folds to the same values.
        run_nxt  = run_c;
        cp_we    = 1'b1;
        cp_wdata = run_c;
        if (i_r != '0) begin
          i_nxt = i_r - 1'b1;
        end
      end
      rlsh_pkg::ST_RF_EMIT: begin
        if (ofree) begin
          out_valid_nxt = 1'b1;
          o_cost_nxt    = '0;
          o_idx_nxt     = i_r;
          o_pos_nxt     = PB'(cp_val + $signed({1'b0, cw_fwd}));
          o_last_nxt    = rf_last;
          o_stat_nxt    = rlsh_pkg::STS_OK;
          i_nxt         = i_r + 1'b1;
        end
      end
      rlsh_pkg::ST_EMIT: begin
        if (ofree) begin
          out_valid_nxt = 1'b1;
          if (cost_r < 0) begin
            o_cost_nxt = '0;
          end else if (cost_r > $signed({1'b0, rlsh_pkg::ACC_W'(rlsh_pkg::COST_MAX)})) begin
            o_cost_nxt = rlsh_pkg::COST_MAX;
          end else begin
            o_cost_nxt = rlsh_pkg::COST_W'(cost_r);
          end
          o_idx_nxt  = '0;
          o_pos_nxt  = '0;
          o_last_nxt = 1'b1;
          o_stat_nxt = stat_r;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlsh_pkg::ST_IDLE;
      cell_cnt_r  <= '0;
      hcnt_r      <= '0;
      k_r         <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
      row_begin_r <= '0;
      row_end_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cell_cnt_r  <= cell_cnt_nxt;
      hcnt_r      <= hcnt_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && pready) begin
        case (rlsh_pkg::reg_idx_t'(paddr[2]))
          rlsh_pkg::REG_ROW_BEGIN: row_begin_r <= $signed(pwdata[PB-1:0]);
          rlsh_pkg::REG_ROW_END:   row_end_r   <= $signed(pwdata[PB-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    w_r        <= w_nxt;
    tgt_r      <= tgt_nxt;
    used_r     <= used_nxt;
    tabs_r     <= tabs_nxt;
    limit_r    <= limit_nxt;
    cur_r      <= cur_nxt;
    slope_r    <= slope_nxt;
    fin_r      <= fin_nxt;
    cost_r     <= cost_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    prod_r     <= mul_a_r * mul_b_r;
    stat_r     <= stat_nxt;
    ins_pos_r  <= ins_pos_nxt;
    ins_wt_r   <= ins_wt_nxt;
    ins2_pos_r <= ins2_pos_nxt;
    ins2_wt_r  <= ins2_wt_nxt;
    ins2_r     <= ins2_nxt;
    run_r      <= run_nxt;
    o_cost_r   <= o_cost_nxt;
    o_idx_r    <= o_idx_nxt;
    o_pos_r    <= o_pos_nxt;
    o_last_r   <= o_last_nxt;
    o_stat_r   <= o_stat_nxt;
  end

  // --------------------------------------------------------------------------
  // Memories.
  // --------------------------------------------------------------------------
  // Breakpoints sorted by position, the largest at the highest used entry.
  rlsh_ram #(
    .WIDTH(rlsh_pkg::HEAP_W),
    .DEPTH(rlsh_pkg::HEAP_DEPTH)
  ) u_heap (
    .clk  (clk),
    .we   (heap_we),
    .waddr(heap_waddr),
    .wdata(heap_wdata),
    .raddr(heap_raddr),
    .rdata(heap_rdata)
  );

  // Cumulative widths; entry zero is never read from the RAM.
  rlsh_ram #(
    .WIDTH(rlsh_pkg::CW_W),
    .DEPTH(rlsh_pkg::MAX_CELLS + 1)
  ) u_cumw (
    .clk  (clk),
    .we   (cw_we),
    .waddr(cw_waddr),
    .wdata(cw_wdata),
    .raddr(cw_raddr),
    .rdata(cw_rdata)
  );

  // Constraining position of each cell.
  rlsh_ram #(
    .WIDTH(PB),
    .DEPTH(rlsh_pkg::MAX_CELLS)
  ) u_cpos (
    .clk  (clk),
    .we   (cp_we),
    .waddr(cp_waddr),
    .wdata(cp_wdata),
    .raddr(i_r),
    .rdata(cp_rdata)
  );

  // --------------------------------------------------------------------------
  // Ports.
  // --------------------------------------------------------------------------
  assign in_tready  = (state_r == rlsh_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_pos_r, o_idx_r, o_cost_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_stat_r;

  assign pready = 1'b1;
  assign prdata = (rlsh_pkg::reg_idx_t'(paddr[2]) == rlsh_pkg::REG_ROW_END)
                  ? 32'(row_end_r) : 32'(row_begin_r);

endmodule
